// ----- rtl/assert_macros.svh -----
// assertion macros used by trace_baseline_subtract
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tbs_pkg.sv -----
// package for the trace baseline subtract block: widths and state type
// no dependencies
package tbs_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int SAMPLE_W   = 14;
  localparam int STAMP_W    = 16;
  localparam int OUT_W      = SAMPLE_W + 1;
  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W      = SAMPLE_W + ADDR_W;
  localparam int PROD_W     = SAMPLE_W + CNT_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int REM_W      = SUM_W + 2;
  localparam int QUO_W      = SAMPLE_W;
  localparam int STEP_W     = $clog2(QUO_W);

  typedef logic [SAMPLE_W-1:0]     sample_t;
  typedef logic [STAMP_W-1:0]      stamp_t;
  typedef logic signed [OUT_W-1:0] corr_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } tbs_state_t;

endpackage

// ----- rtl/tbs_if.sv -----
// valid/ready channel interfaces for the input and result streams
// depends on tbs_pkg
interface tbs_in_if;
  import tbs_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  stamp_t  timestamp;
  stamp_t  cutoff_time;
  logic    last_frame;
  modport source (output valid, sample, timestamp, cutoff_time, last_frame, input ready);
  modport sink   (input valid, sample, timestamp, cutoff_time, last_frame, output ready);
endinterface

interface tbs_out_if;
  import tbs_pkg::*;
  logic  valid;
  logic  ready;
  corr_t corrected;
  logic  last_out;
  modport source (output valid, corrected, last_out, input ready);
  modport sink   (input valid, corrected, last_out, output ready);
endinterface

// ----- rtl/trace_baseline_subtract.sv -----
// Pre-trigger baseline subtraction for one well trace. Samples arrive one per
// transfer on in_ch and are written to a 64-entry sample memory, one transfer per
// cycle. Leading samples whose timestamp is strictly below their own cutoff_time
// are summed and counted until the first one that fails; later samples are only
// stored, and samples beyond 64 are dropped. The transfer marked last_frame starts
// the emit phase: every stored sample leaves on out_ch as sample minus the mean of
// the averaged samples, rounded half away from zero (the first sample is the
// offset when none qualified). In the emit phase each result passes through
// one memory read state, one multiply state, 14 steps of a radix-2 restoring
// divider and one output state. With no averaged sample the divider is
// bypassed. No input is taken during the emit phase; the block is ready for
// the next trace in the cycle after the final result transfer. There is no
// clearing pass after reset.
// depends on tbs_pkg, tbs_if and assert_macros.svh
`include "assert_macros.svh"

module trace_baseline_subtract (
  input  logic      clk,
  input  logic      rst_n,
  tbs_in_if.sink    in_ch,
  tbs_out_if.source out_ch
);
  import tbs_pkg::*;

  // sample memory, with a registered read
  sample_t mem [MAX_FRAMES];
  sample_t rd_data_r;

  // control state
  tbs_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] frame_idx_r, frame_idx_nxt;   // number of stored samples
  logic [CNT_W-1:0] cnt_r, cnt_nxt;               // averaged sample count
  logic [SUM_W-1:0] sum_r, sum_nxt;               // averaged sample sum
  logic             avg_r, avg_nxt;               // still in the averaging run
  logic [ADDR_W-1:0] emit_idx_r, emit_idx_nxt;    // entry being emitted
  logic [STEP_W-1:0] step_r, step_nxt;            // divider step, counts down

  // payload state
  sample_t          first_r, first_nxt;           // copy of entry zero
  logic [REM_W-1:0] rem_r, rem_nxt;               // divider partial remainder
  logic [REM_W-1:0] div_r, div_nxt;               // shifted divisor
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             neg_r, neg_nxt;
  corr_t            corr_r, corr_nxt;

  logic                    in_xfer, out_xfer, wr_en, emit_last;
  logic [PROD_W-1:0]       prod;
  logic signed [NUM_W-1:0] num, mag;
  logic [QUO_W-1:0]        quo_step;
  logic                    rem_ge;

  assign in_ch.ready      = (state_r == ST_LOAD);
  assign out_ch.valid     = (state_r == ST_OUT);
  assign out_ch.corrected = corr_r;
  assign out_ch.last_out  = emit_last;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign wr_en     = in_xfer && (frame_idx_r < CNT_W'(MAX_FRAMES));
  assign emit_last = ((CNT_W'(emit_idx_r) + CNT_W'(1)) == frame_idx_r);

  // memory port: write on load, registered read for emit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[frame_idx_r[ADDR_W-1:0]] <= in_ch.sample;
    end
    rd_data_r <= mem[emit_idx_r];
  end

  // numerator sample*count - sum and its magnitude
  assign prod = PROD_W'(rd_data_r) * PROD_W'(cnt_r);
  assign num  = $signed({1'b0, prod}) - $signed(NUM_W'(sum_r));
  assign mag  = num[NUM_W-1] ? -num : num;

  // one restoring division step
  assign rem_ge   = (rem_r >= div_r);
  assign quo_step = {quo_r[QUO_W-2:0], rem_ge};

  always_comb begin
    state_nxt     = state_r;
    frame_idx_nxt = frame_idx_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    emit_idx_nxt  = emit_idx_r;
    step_nxt      = step_r;
    first_nxt     = first_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    corr_nxt      = corr_r;

    case (state_r)
      ST_LOAD: begin
        if (wr_en) begin
          frame_idx_nxt = frame_idx_r + CNT_W'(1);
          if (frame_idx_r == '0) begin
            first_nxt = in_ch.sample;
          end
          if (avg_r) begin
            if (in_ch.timestamp < in_ch.cutoff_time) begin
              sum_nxt = sum_r + SUM_W'(in_ch.sample);
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              avg_nxt = 1'b0;
            end
          end
        end
        if (in_xfer && in_ch.last_frame) begin
          emit_idx_nxt = '0;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        // address is emit_idx_r, data lands in rd_data_r
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_r == '0) begin
          corr_nxt  = $signed({1'b0, rd_data_r}) - $signed({1'b0, first_r});
          state_nxt = ST_OUT;
        end else begin
          // round half away from zero: (2|num| + cnt) / (2 cnt)
          neg_nxt   = num[NUM_W-1];
          rem_nxt   = REM_W'({mag[SUM_W-1:0], 1'b0}) + REM_W'(cnt_r);
          div_nxt   = REM_W'({cnt_r, 1'b0}) << (QUO_W - 1);
          quo_nxt   = '0;
          step_nxt  = STEP_W'(QUO_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_nxt = rem_r - div_r;
        end
        div_nxt = div_r >> 1;
        quo_nxt = quo_step;
        if (step_r == '0) begin
          corr_nxt  = neg_r ? (OUT_W'(0) - {1'b0, quo_step}) : {1'b0, quo_step};
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          if (emit_last) begin
            // trace done, back to an empty accumulator
            frame_idx_nxt = '0;
            cnt_nxt       = '0;
            sum_nxt       = '0;
            avg_nxt       = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            emit_idx_nxt = emit_idx_r + ADDR_W'(1);
            state_nxt    = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      frame_idx_r <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      avg_r       <= 1'b1;
      emit_idx_r  <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      frame_idx_r <= frame_idx_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      emit_idx_r  <= emit_idx_nxt;
      step_r      <= step_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    quo_r   <= quo_nxt;
    neg_r   <= neg_nxt;
    corr_r  <= corr_nxt;
  end

  // checks
  `TBS_ASSERT_NOW(a_no_overlap, in_ch.ready, !out_ch.valid, "input and output phases overlap")
  `TBS_ASSERT_NOW(a_cnt_le_frames, 1'b1, cnt_r <= frame_idx_r, "averaged count exceeds stored samples")
  `TBS_ASSERT_NOW(a_frames_bound, 1'b1, frame_idx_r <= CNT_W'(MAX_FRAMES), "frame index beyond memory")
  `TBS_ASSERT_NEXT(a_last_frees, out_xfer && emit_last, in_ch.ready && frame_idx_r == '0, "trace not released after final result")
  `TBS_ASSERT_NOW(a_emit_in_range, state_r == ST_OUT, CNT_W'(emit_idx_r) < frame_idx_r, "emit index past stored samples")

endmodule
